// File: rtl/xad_pkg.sv
`default_nettype none

package xad_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int SKIP_BYTES  = 8;
    localparam int SIZE_BYTES  = 4;
    localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = ENTRY_AW + 1;
    localparam int SIZE_W      = 32;
    localparam int TAG_W       = 8;
    localparam int STORE_W     = TAG_W + SIZE_W;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [7:0]       XOR_KEY_RESET = 8'hF7;
    localparam logic [7:0]       SKIP_COUNT    = 8'(SKIP_BYTES);
    localparam logic [7:0]       SIZE_LAST     = 8'(SIZE_BYTES - 1);
    localparam logic [CNT_W-1:0] MAX_COUNT     = CNT_W'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_NAMELEN,
        PH_NAME,
        PH_SIZE,
        PH_DATA,
        PH_ERR
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NAME   = 3'd0,
        KIND_HEADER = 3'd1,
        KIND_DATA   = 3'd2,
        KIND_END_OK = 3'd3,
        KIND_ERROR  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_TRUNCATED = 2'd1,
        ERR_TOO_MANY  = 2'd2,
        ERR_MISMATCH  = 2'd3
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic [7:0]  entry_number;
        logic        entry_last;
        err_t        error_code;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/xad_ram.sv
`default_nettype none

module xad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/xad_result_fifo.sv
`default_nettype none

module xad_result_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       push_cnt,
    input  wire xad_pkg::result_t push0,
    input  wire xad_pkg::result_t push1,
    output logic                  room2,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output xad_pkg::result_t      pop_data
);

    import xad_pkg::*;

    result_t              slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 pop;
    logic [FIFO_AW-1:0]   wr_ptr_plus1;

    assign pop          = pop_valid && pop_ready;
    assign pop_valid    = (count_reg != '0);
    assign pop_data     = slot_reg[rd_ptr_reg];
    assign room2        = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_AW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_cnt);
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(push_cnt) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            slot_reg[wr_ptr_plus1] <= push1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overfilled");

endmodule

`default_nettype wire

// File: rtl/xor_archive_directory_deframer.sv
// Results are written into the four-beat result queue as archive bytes are accepted and
// leave from its head. Throughput: one archive byte per cycle while the queue has room for
// two results, as the final byte may queue two; otherwise in_ready stays low.
// Reset (rst_n low, asynchronous): parser state and the queue clear, xor_key returns to
// 0xF7. The size store is not cleared; only entries written in the current archive are read.
`default_nettype none

module xor_archive_directory_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  raw_byte,
    input  wire logic        end_of_archive,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       kind,
    output logic [31:0]      value,
    output logic [7:0]       entry_number,
    output logic             entry_last,
    output logic [1:0]       error_code
);

    import xad_pkg::*;

    logic [7:0]          xor_key_reg;
    phase_t              phase_reg, phase_next;
    logic [7:0]          field_cnt_reg, field_cnt_next;
    logic [SIZE_W-1:0]   size_acc_reg, size_acc_next;
    logic [8:0]          entry_cnt_reg, entry_cnt_next;
    logic [SIZE_W-1:0]   declared_reg, declared_next;
    logic [SIZE_W-1:0]   data_seen_reg, data_seen_next;
    logic [CNT_W-1:0]    stored_cnt_reg, stored_cnt_next;
    logic [CNT_W-1:0]    read_pos_reg, read_pos_next;
    logic [SIZE_W-1:0]   remaining_reg, remaining_next;
    err_t                err_reg, err_next;

    logic                accept;
    logic [7:0]          b;
    logic [SIZE_W-1:0]   acc_new;
    logic [SIZE_W-1:0]   eff_rem;
    logic                rp_valid;
    logic [1:0]          push_cnt;
    result_t             res0, res1, status, head;
    logic                room2;
    logic                mem_we;
    logic [STORE_W-1:0]  mem_wdata, mem_rdata;

    assign accept   = in_valid && in_ready;
    assign in_ready = room2;
    assign b        = raw_byte ^ xor_key_reg;
    assign rp_valid = (read_pos_reg < stored_cnt_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        field_cnt_next  = field_cnt_reg;
        size_acc_next   = size_acc_reg;
        entry_cnt_next  = entry_cnt_reg;
        declared_next   = declared_reg;
        data_seen_next  = data_seen_reg;
        stored_cnt_next = stored_cnt_reg;
        read_pos_next   = read_pos_reg;
        remaining_next  = remaining_reg;
        err_next        = err_reg;
        push_cnt        = 2'd0;
        res0            = '0;
        res1            = '0;
        status          = '0;
        mem_we          = 1'b0;
        acc_new         = size_acc_reg | (SIZE_W'(b) << {field_cnt_reg[1:0], 3'b000});
        mem_wdata       = {entry_cnt_reg[TAG_W-1:0], acc_new};
        eff_rem         = (remaining_reg == '0 && rp_valid) ? mem_rdata[SIZE_W-1:0]
                                                            : remaining_reg;

        if (accept)
        begin
            case (phase_reg)
                PH_SKIP:
                begin
                    if (field_cnt_reg < SKIP_COUNT)
                    begin
                        field_cnt_next = field_cnt_reg + 8'd1;
                    end
                    else if (b != 8'd0)
                    begin
                        phase_next     = PH_DATA;
                        field_cnt_next = '0;
                    end
                    else if (stored_cnt_reg >= MAX_COUNT)
                    begin
                        err_next   = ERR_TOO_MANY;
                        phase_next = PH_ERR;
                    end
                    else
                    begin
                        phase_next     = PH_NAMELEN;
                        field_cnt_next = '0;
                    end
                end
                PH_NAMELEN:
                begin
                    field_cnt_next = b;
                    size_acc_next  = '0;
                    phase_next     = (b == 8'd0) ? PH_SIZE : PH_NAME;
                end
                PH_NAME:
                begin
                    res0.kind         = KIND_NAME;
                    res0.value        = 32'(b);
                    res0.entry_number = entry_cnt_reg[7:0];
                    res0.entry_last   = (field_cnt_reg == 8'd1);
                    push_cnt          = 2'd1;
                    field_cnt_next    = field_cnt_reg - 8'd1;
                    if (field_cnt_reg == 8'd1)
                    begin
                        phase_next = PH_SIZE;
                    end
                end
                PH_SIZE:
                begin
                    size_acc_next  = acc_new;
                    field_cnt_next = field_cnt_reg + 8'd1;
                    if (field_cnt_reg >= SIZE_LAST)
                    begin
                        res0.kind         = KIND_HEADER;
                        res0.value        = acc_new;
                        res0.entry_number = entry_cnt_reg[7:0];
                        push_cnt          = 2'd1;
                        declared_next     = declared_reg + acc_new;
                        if (acc_new != '0 && stored_cnt_reg < MAX_COUNT)
                        begin
                            mem_we          = 1'b1;
                            stored_cnt_next = stored_cnt_reg + CNT_W'(1);
                        end
                        entry_cnt_next = entry_cnt_reg + 9'd1;
                        size_acc_next  = '0;
                        field_cnt_next = '0;
                        phase_next     = PH_SKIP;
                    end
                end
                PH_DATA:
                begin
                    data_seen_next = data_seen_reg + SIZE_W'(1);
                    remaining_next = eff_rem;
                    if (eff_rem != '0 && rp_valid)
                    begin
                        res0.kind         = KIND_DATA;
                        res0.value        = 32'(b);
                        res0.entry_number = mem_rdata[STORE_W-1:SIZE_W];
                        res0.entry_last   = (eff_rem == SIZE_W'(1));
                        push_cnt          = 2'd1;
                        remaining_next    = eff_rem - SIZE_W'(1);
                        if (eff_rem == SIZE_W'(1))
                        begin
                            read_pos_next = read_pos_reg + CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (end_of_archive)
            begin
                if (err_next != ERR_NONE)
                begin
                    status.kind       = KIND_ERROR;
                    status.error_code = err_next;
                end
                else if (phase_next != PH_DATA)
                begin
                    status.kind       = KIND_ERROR;
                    status.error_code = ERR_TRUNCATED;
                end
                else if (declared_next != data_seen_next)
                begin
                    status.kind       = KIND_ERROR;
                    status.error_code = ERR_MISMATCH;
                end
                else
                begin
                    status.kind = KIND_END_OK;
                end

                if (push_cnt == 2'd0)
                begin
                    res0 = status;
                end
                else
                begin
                    res1 = status;
                end
                push_cnt = push_cnt + 2'd1;

                phase_next      = PH_SKIP;
                field_cnt_next  = '0;
                size_acc_next   = '0;
                entry_cnt_next  = '0;
                declared_next   = '0;
                data_seen_next  = '0;
                stored_cnt_next = '0;
                read_pos_next   = '0;
                remaining_next  = '0;
                err_next        = ERR_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_key_reg    <= XOR_KEY_RESET;
            phase_reg      <= PH_SKIP;
            field_cnt_reg  <= '0;
            size_acc_reg   <= '0;
            entry_cnt_reg  <= '0;
            declared_reg   <= '0;
            data_seen_reg  <= '0;
            stored_cnt_reg <= '0;
            read_pos_reg   <= '0;
            remaining_reg  <= '0;
            err_reg        <= ERR_NONE;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                xor_key_reg <= cfg_wr_data;
            end
            phase_reg      <= phase_next;
            field_cnt_reg  <= field_cnt_next;
            size_acc_reg   <= size_acc_next;
            entry_cnt_reg  <= entry_cnt_next;
            declared_reg   <= declared_next;
            data_seen_reg  <= data_seen_next;
            stored_cnt_reg <= stored_cnt_next;
            read_pos_reg   <= read_pos_next;
            remaining_reg  <= remaining_next;
            err_reg        <= err_next;
        end
    end

    // The store is read at the next read position, so its registered output always
    // holds the entry for the current read position when a data byte arrives.
    xad_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_ENTRIES)
    ) u_size_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (stored_cnt_reg[ENTRY_AW-1:0]),
        .wdata (mem_wdata),
        .raddr (read_pos_next[ENTRY_AW-1:0]),
        .rdata (mem_rdata)
    );

    xad_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .room2     (room2),
        .pop_valid (out_valid),
        .pop_ready (out_ready),
        .pop_data  (head)
    );

    assign kind         = head.kind;
    assign value        = head.value;
    assign entry_number = head.entry_number;
    assign entry_last   = head.entry_last;
    assign error_code   = head.error_code;

    a_read_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        read_pos_reg <= stored_cnt_reg)
        else $error("read position passed the stored entry count");

    a_remaining_owned: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg != '0 |-> read_pos_reg < stored_cnt_reg)
        else $error("data bytes pending with no stored entry");

    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERR |-> err_reg == ERR_TOO_MANY)
        else $error("error phase without a latched error");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_archive |=> phase_reg == PH_SKIP && stored_cnt_reg == '0
            && err_reg == ERR_NONE)
        else $error("parser not cleared after the final beat");

endmodule

`default_nettype wire
